// ===== rtl/mmf_pkg.sv =====
package mmf_pkg;

	localparam int CHANNELS     = 2;
	localparam int WINDOW_SLOTS = 11;
	localparam int DATA_W       = 32;
	localparam int WLEN_W       = 4;
	localparam int WLEN_RESET   = 5;
	localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
	localparam int DEPTH        = CHANNELS * WINDOW_SLOTS;
	localparam int ADDR_W       = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAND,
		ST_LOAD,
		ST_CMP,
		ST_DONE
	} mmf_state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} mmf_wr_t;

	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] median;
	} mmf_res_t;

	function automatic logic [ADDR_W-1:0] mmf_addr(input logic [CH_W-1:0] ch,
		input logic [SLOT_W-1:0] slot);
		return ADDR_W'(int'(ch) * WINDOW_SLOTS + int'(slot));
	endfunction

endpackage

// ===== rtl/mmf_store.sv =====
module mmf_store
	import mmf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mmf_wr_t           wr,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] rdata_q;
	logic              rvalid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata_q <= mem_q[raddr];
	end

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			rvalid_q <= valid_q[raddr];
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/mmf_seq.sv =====
module mmf_seq
	import mmf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              channel,
	input  logic [DATA_W-1:0] sample,
	input  logic [WLEN_W-1:0] window_len,
	output mmf_wr_t           wr,
	output logic [ADDR_W-1:0] raddr,
	input  logic [DATA_W-1:0] rdata,
	output mmf_res_t          res,
	input  logic              res_take
);

	mmf_state_t        state_q, state_d;
	logic [CH_W-1:0]   ch_q, ch_d;
	logic [SLOT_W-1:0] elen_q, elen_d, k_q, k_d;
	logic [SLOT_W-1:0] i_q, i_d, j_q, j_d, cnt_q, cnt_d;
	logic [DATA_W-1:0] cand_q, cand_d, res_q, res_d;
	logic [SLOT_W-1:0] pos_q [CHANNELS];

	logic [SLOT_W-1:0] elen_c, pos_cur, pos_new, rank;
	logic [SLOT_W:0]   pos_inc;
	logic              in_range, pos_we, less;

	always_comb begin
		if (window_len == '0) begin
			elen_c = SLOT_W'(1);
		end else if (int'(window_len) > WINDOW_SLOTS - 1) begin
			elen_c = SLOT_W'(WINDOW_SLOTS - 1);
		end else begin
			elen_c = SLOT_W'(window_len);
		end
	end

	assign in_range = int'(channel) < CHANNELS;
	assign pos_cur  = pos_q[CH_W'(channel)];
	assign pos_inc  = {1'b0, pos_cur} + (SLOT_W + 1)'(1);
	assign pos_new  = (pos_inc >= {1'b0, elen_c}) ? '0 : pos_inc[SLOT_W-1:0];

	// Ties are broken by slot so that every slot gets a distinct rank.
	assign less = ($signed(rdata) < $signed(cand_q)) || ((rdata == cand_q) && (j_q < i_q));
	assign rank = cnt_q + SLOT_W'(less);

	always_comb begin
		state_d    = state_q;
		ch_d       = ch_q;
		elen_d     = elen_q;
		k_d        = k_q;
		i_d        = i_q;
		j_d        = j_q;
		cnt_d      = cnt_q;
		cand_d     = cand_q;
		res_d      = res_q;
		pos_we     = 1'b0;
		wr         = '0;
		raddr      = mmf_addr(ch_q, i_q);
		in_stall   = 1'b1;
		res.valid  = 1'b0;
		res.median = res_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (!in_range) begin
						res_d   = '0;
						state_d = ST_DONE;
					end else begin
						wr.en   = 1'b1;
						wr.addr = mmf_addr(CH_W'(channel), pos_new);
						wr.data = sample;
						pos_we  = 1'b1;
						ch_d    = CH_W'(channel);
						elen_d  = elen_c;
						k_d     = elen_c >> 1;
						i_d     = '0;
						state_d = ST_CAND;
					end
				end
			end
			ST_CAND: begin
				raddr   = mmf_addr(ch_q, i_q);
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cand_d  = rdata;
				raddr   = mmf_addr(ch_q, '0);
				j_d     = '0;
				cnt_d   = '0;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				raddr = mmf_addr(ch_q, j_q + SLOT_W'(1));
				j_d   = j_q + SLOT_W'(1);
				cnt_d = rank;
				if (j_q == elen_q - SLOT_W'(1)) begin
					if (rank == k_q) begin
						res_d   = cand_q;
						state_d = ST_DONE;
					end else begin
						i_d     = i_q + SLOT_W'(1);
						state_d = ST_CAND;
					end
				end
			end
			ST_DONE: begin
				res.valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			elen_q  <= '0;
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			cnt_q   <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				pos_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
			elen_q  <= elen_d;
			k_q     <= k_d;
			i_q     <= i_d;
			j_q     <= j_d;
			cnt_q   <= cnt_d;
			if (pos_we) begin
				pos_q[CH_W'(channel)] <= pos_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		cand_q <= cand_d;
		res_q  <= res_d;
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("sequencer idle right after an accepted beat");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (cnt_q <= j_q && j_q < elen_q))
		else $error("rank count or scan index out of range");

	a_candidate_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CAND || state_q == ST_LOAD || state_q == ST_CMP) |-> (i_q < elen_q))
		else $error("no candidate matched the median rank");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !res_take) |=> (state_q == ST_DONE && $stable(res_q)))
		else $error("result dropped before it was taken");

endmodule

// ===== rtl/moving_median_filter_core.sv =====
// Channel  Handshake                 Payload
// in       in_valid / in_stall       channel, sample
// out      out_valid / out_stall     median
// cfg      cfg_wr_en                 cfg_wr_data (window_len)
//
// An item tries c candidates in turn, where L is the effective window length and c
// (1 to L) is the number of candidates tried before the one of median rank is found.
// The single store read port and the one compare unit make this serial: each candidate
// is read, then every slot of the window is read and compared against it.
// Reset clears the store, the write positions and the window length (to five).
// The result register lets the next item be accepted while a median waits on out_stall.
module moving_median_filter_core
	import mmf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     channel,
	input  logic signed [DATA_W-1:0] sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] median,
	input  logic                     cfg_wr_en,
	input  logic        [WLEN_W-1:0] cfg_wr_data
);

	logic [WLEN_W-1:0] wlen_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] median_q;
	mmf_wr_t           wr;
	mmf_res_t          res;
	logic [ADDR_W-1:0] raddr;
	logic [DATA_W-1:0] rdata;
	logic              res_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_W'(WLEN_RESET);
		end else if (cfg_wr_en) begin
			wlen_q <= cfg_wr_data;
		end
	end

	mmf_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	mmf_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.channel    (channel),
		.sample     (sample),
		.window_len (wlen_q),
		.wr         (wr),
		.raddr      (raddr),
		.rdata      (rdata),
		.res        (res),
		.res_take   (res_take)
	);

	assign res_take = res.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			median_q <= res.median;
		end
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;

endmodule

// ===== tb/mmf_median_checker.sv =====
module mmf_median_checker
	import mmf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic                     channel,
	input  logic signed [DATA_W-1:0] sample,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [DATA_W-1:0] median,
	input  logic                     cfg_wr_en,
	input  logic        [WLEN_W-1:0] cfg_wr_data,
	output int                       fail_count,
	output int                       outstanding,
	output int                       medians_checked
);

	timeunit 1ns;
	timeprecision 1ps;

	logic signed [DATA_W-1:0] window_store [CHANNELS][WINDOW_SLOTS];
	logic        [SLOT_W-1:0] fill_slot [CHANNELS];
	logic        [WLEN_W-1:0] window_len;
	logic signed [DATA_W-1:0] median_q [$];
	logic signed [DATA_W-1:0] expected_median;

	// Stores the sample in its channel's window and returns the window's median.
	function automatic logic signed [DATA_W-1:0] insert_and_median(input logic ch,
		input logic signed [DATA_W-1:0] smp);
		logic signed [DATA_W-1:0] sorted [WINDOW_SLOTS];
		logic signed [DATA_W-1:0] t;
		int len;
		int pos;
		int i;
		int j;
		len = int'(window_len);
		if (len < 1)
			len = 1;
		if (len > WINDOW_SLOTS - 1)
			len = WINDOW_SLOTS - 1;
		pos = int'(fill_slot[ch]) + 1;
		if (pos >= len)
			pos = 0;
		fill_slot[ch] = SLOT_W'(pos);
		window_store[ch][pos] = smp;
		for (i = 0; i < len; i++)
			sorted[i] = window_store[ch][i];
		for (i = 0; i + 1 < len; i++) begin
			for (j = 0; j + 1 < len - i; j++) begin
				if (sorted[j] > sorted[j + 1]) begin
					t = sorted[j];
					sorted[j] = sorted[j + 1];
					sorted[j + 1] = t;
				end
			end
		end
		return sorted[len / 2];
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				fill_slot[c] = '0;
				for (int s = 0; s < WINDOW_SLOTS; s++)
					window_store[c][s] = '0;
			end
			window_len = WLEN_W'(WLEN_RESET);
			median_q.delete();
			fail_count = 0;
			outstanding = 0;
			medians_checked = 0;
		end else begin
			if (cfg_wr_en)
				window_len = cfg_wr_data;
			if (in_valid && !in_stall)
				median_q.push_back(insert_and_median(channel, sample));
			if (out_valid && !out_stall) begin
				medians_checked++;
				if (median_q.size() == 0) begin
					note_failure($sformatf("median beat with none expected: got %0d (0x%08h)",
						median, median));
				end else begin
					expected_median = median_q.pop_front();
					if (median !== expected_median)
						note_failure($sformatf("median mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
							expected_median, expected_median, median, median));
				end
			end
			outstanding = median_q.size();
		end
	end

endmodule

// ===== tb/tb_moving_median_filter_core.sv =====
module tb_moving_median_filter_core
	import mmf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 144;
	localparam int HOLD_CYCLES = 400;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     channel = 1'b0;
	logic signed [DATA_W-1:0] sample = '0;
	logic                     out_stall = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic        [WLEN_W-1:0] cfg_wr_data = '0;
	logic                     in_stall;
	logic                     out_valid;
	logic signed [DATA_W-1:0] median;

	int fail_count;
	int outstanding;
	int medians_checked;
	int items_sent = 0;
	int cfg_writes = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	always #10 clk = ~clk;

	moving_median_filter_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.channel    (channel),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.median     (median),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	mmf_median_checker median_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.channel        (channel),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.median         (median),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.medians_checked(medians_checked)
	);

	task automatic send_sample(input logic ch, input logic [DATA_W-1:0] smp);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		channel <= ch;
		sample <= smp;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_window_len(input logic [WLEN_W-1:0] value);
		drain_results();
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cfg_writes++;
	endtask

	function automatic logic [DATA_W-1:0] random_sample();
		logic [DATA_W-1:0] pool [4];
		pool = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0002_8000};
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return DATA_W'(int'($urandom_range(0, 64)) - 32);
			3, 4: return pool[$urandom_range(0, 3)];
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int stall;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 3) : 0;
			if (hold_req && !held) begin
				held = 1'b1;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				out_stall <= 1'b1;
				repeat (stall) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		logic [WLEN_W-1:0] wlen;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_sample(1'b0, 32'h7FFF_FFFF);
		send_sample(1'b0, 32'h8000_0000);
		send_sample(1'b0, 32'hFFFF_FFFF);
		send_sample(1'b0, 32'h0000_0001);
		send_sample(1'b0, 32'h7FFF_FFFF);
		send_sample(1'b0, 32'h8000_0000);
		repeat (3) send_sample(1'b1, 32'h1234_5678);
		write_window_len(4'd0);
		send_sample(1'b0, 32'h8000_0000);
		send_sample(1'b1, 32'h7FFF_FFFF);
		write_window_len(4'd15);
		for (int k = 0; k < 6; k++)
			send_sample(1'b0, (k % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000);
		send_sample(1'b1, 32'h0000_0000);
		send_sample(1'b1, 32'hFFFF_FFFF);
		write_window_len(4'd2);
		send_sample(1'b0, 32'h0000_0005);
		send_sample(1'b0, 32'hFFFF_FFFB);
		send_sample(1'b0, 32'h0000_0003);
		send_sample(1'b1, 32'h0000_0001);
		send_sample(1'b1, 32'h0000_0001);
		write_window_len(4'd11);
		send_sample(1'b1, 32'h8000_0000);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: wlen = 4'd10;
				1: wlen = 4'd0;
				2: wlen = 4'd15;
				3: wlen = 4'd1;
				default: wlen = WLEN_W'($urandom_range(0, 15));
			endcase
			write_window_len(wlen);
			idle_on = (p % 3 != 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 4 && k == 20)
					hold_req = 1'b1;
				if (p == 6 && k == 70) begin
					drain_results();
					@(negedge clk);
				end
				send_sample(1'($urandom_range(0, 1)), random_sample());
			end
		end

		idle_on = 1'b1;
		drain_results();
		repeat (150) @(negedge clk);
		$display("Sent %0d samples on both channels across %0d window length writes (0 to 15).",
			items_sent, cfg_writes);
		$display("Compared %0d medians; %0d failures.", medians_checked, fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d medians still expected.", outstanding);
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mmf_pkg.sv
rtl/mmf_store.sv
rtl/mmf_seq.sv
rtl/moving_median_filter_core.sv
tb/mmf_median_checker.sv
tb/tb_moving_median_filter_core.sv
